### design/dmcr_pkg.sv
// Package for the dual-matrix color remap unit.
// Holds the fixed-point types, the Q16 coefficient tables and the arithmetic helpers.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package dmcr_pkg;

  // Fixed-point layout: coefficients are signed Q16 values.
  localparam int unsigned FracBits = 16;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CoefW    = 18;
  localparam int unsigned AccW     = 28;
  localparam int unsigned HalfLsb  = 32768;

  typedef logic        [ChanW-1:0] chan_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // Index of each matrix on the matrix_used output.
  localparam logic MatA = 1'b0;
  localparam logic MatB = 1'b1;

  // Selection weights, Q16: [sum][channel].
  localparam coef_t SelW [2][3] = '{
    '{coef_t'(655),   coef_t'(4356),  coef_t'(47953)},
    '{coef_t'(10052), coef_t'(20750), coef_t'(3744)}
  };

  // Remap matrices, Q16: [matrix][row][column].
  localparam coef_t RemapM [2][3][3] = '{
    '{
      '{coef_t'(27940), coef_t'(56171), coef_t'(5251)},
      '{coef_t'(18422), coef_t'(37434), -coef_t'(2573)},
      '{-coef_t'(1160), coef_t'(1770),  coef_t'(65698)}
    },
    '{
      '{coef_t'(49683), coef_t'(95281), -coef_t'(97033)},
      '{coef_t'(7768),  coef_t'(18848), coef_t'(47546)},
      '{-coef_t'(489),  coef_t'(2941),  coef_t'(62541)}
    }
  };

  // Dot product of one coefficient row with an RGB color, full width.
  function automatic acc_t dot3(input coef_t w0, input coef_t w1, input coef_t w2,
                                input chan_t r, input chan_t g, input chan_t b);
    acc_t p0;
    acc_t p1;
    acc_t p2;
    p0 = acc_t'(w0) * acc_t'(r);
    p1 = acc_t'(w1) * acc_t'(g);
    p2 = acc_t'(w2) * acc_t'(b);
    return p0 + p1 + p2;
  endfunction

  // Round a Q16 value half away from zero and clamp it to 0..255.
  function automatic chan_t round_clamp(input acc_t v);
    logic [AccW:0] t;
    t = {1'b0, v} + (AccW+1)'(HalfLsb);
    if (v[AccW-1]) begin
      return '0;
    end
    if (|t[AccW:FracBits+ChanW]) begin
      return '1;
    end
    return t[FracBits+ChanW-1:FracBits];
  endfunction

endpackage

`default_nettype wire

### design/dual_matrix_color_remap_unit.sv
// Top level of the dual-matrix color remap unit: input register, remap logic, result register.
// Depends on dmcr_pkg for the coefficient tables, types and rounding helpers.
`timescale 1ns / 1ps
`default_nettype none

// Remaps one RGB color (8 bits per channel) per beat. Two weighted sums of the
// channels pick one of two fixed 3x3 matrices; each output channel is that
// matrix row times the color, rounded half away from zero and clamped to
// 0..255, and matrix_used_o tells which matrix was taken. The unit takes one
// color in every clock cycle unless back-pressure stalls it; each color is
// held in the input register and its result in the result register. All
// products have constant coefficients, so the whole remap fits between those
// two registers. Both sides stall independently through the valid and ready
// handshakes; a full result register under back-pressure still lets the
// input register take one more beat.
module dual_matrix_color_remap_unit
  import dmcr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire chan_t red_in_i,
  input  wire chan_t green_in_i,
  input  wire chan_t blue_in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output chan_t      red_out_o,
  output chan_t      green_out_o,
  output chan_t      blue_out_o,
  output logic       matrix_used_o
);

  logic  in_valid_q;
  chan_t red_q, green_q, blue_q;
  logic  out_valid_q;
  chan_t red_out_q, green_out_q, blue_out_q;
  logic  matrix_used_q;

  logic  out_ready;
  acc_t  sel_sum0, sel_sum1;
  logic  matrix_sel;
  acc_t  acc_a [3];
  acc_t  acc_b [3];
  chan_t chan_d [3];

  // Handshake: each stage moves when its successor has room.
  assign out_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
    end
  end

  // Matrix selection from the truncated weighted sums.
  always_comb begin
    sel_sum0 = dot3(SelW[0][0], SelW[0][1], SelW[0][2], red_q, green_q, blue_q);
    sel_sum1 = dot3(SelW[1][0], SelW[1][1], SelW[1][2], red_q, green_q, blue_q);
    if (sel_sum0[AccW-1:FracBits] < sel_sum1[AccW-1:FracBits]) begin
      matrix_sel = MatA;
    end else begin
      matrix_sel = MatB;
    end
  end

  // Both matrices are evaluated side by side, then the chosen row set is rounded.
  always_comb begin
    for (int row = 0; row < 3; row++) begin
      acc_a[row] = dot3(RemapM[0][row][0], RemapM[0][row][1], RemapM[0][row][2],
                        red_q, green_q, blue_q);
      acc_b[row] = dot3(RemapM[1][row][0], RemapM[1][row][1], RemapM[1][row][2],
                        red_q, green_q, blue_q);
      chan_d[row] = round_clamp((matrix_sel == MatB) ? acc_b[row] : acc_a[row]);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      red_out_q     <= chan_d[0];
      green_out_q   <= chan_d[1];
      blue_out_q    <= chan_d[2];
      matrix_used_q <= matrix_sel;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_out_o     = red_out_q;
  assign green_out_o   = green_out_q;
  assign blue_out_o    = blue_out_q;
  assign matrix_used_o = matrix_used_q;

  // The input side only stalls when both stages hold a beat.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled while a stage was empty");

  // A beat in the input register is never dropped while the output is blocked.
  a_hold_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |=> in_valid_q)
    else $error("input stage beat lost under back-pressure");

  // A beat that leaves the input register lands in the result register.
  a_beat_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_ready) |=> out_valid_q)
    else $error("beat did not reach the result register");

  // A result only appears when the input register held a beat.
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without an input beat");

endmodule

`default_nettype wire

### sim/dual_matrix_color_remap_checker.sv
// Checker for the dual-matrix color remap unit: watches both channels, predicts each result
// from the accepted color, and compares it field by field with what the unit hands out.
// Depends on dmcr_pkg for the channel type and the matrix codes.
`timescale 1ns / 1ps

module dual_matrix_color_remap_checker
  import dmcr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  chan_t red_in_i,
  input  chan_t green_in_i,
  input  chan_t blue_in_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  chan_t red_out_i,
  input  chan_t green_out_i,
  input  chan_t blue_out_i,
  input  logic  matrix_used_i,
  output int    mismatch_count_o,
  output int    pending_o,
  output int    checked_o,
  output int    mat_b_count_o
);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  matrix;
  } remap_result_t;

  remap_result_t remap_q[$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    checked_o        = 0;
    mat_b_count_o    = 0;
  end

  // Rounds a Q16 value half away from zero and saturates it to one channel.
  function automatic chan_t round_sat(input longint acc);
    longint q;
    if (acc < 0) begin
      return '0;
    end
    q = (acc + 32768) >>> 16;
    if (q > 255) begin
      return 8'd255;
    end
    return chan_t'(q);
  endfunction

  // Expected remap of one color: the two selection sums pick the matrix, then
  // each output channel is one row of that matrix times the color.
  function automatic remap_result_t remap_color(input chan_t r, input chan_t g,
                                                input chan_t b);
    longint        rv;
    longint        gv;
    longint        bv;
    longint        sum_a;
    longint        sum_b;
    remap_result_t res;
    rv    = {56'd0, r};
    gv    = {56'd0, g};
    bv    = {56'd0, b};
    sum_a = (655 * rv + 4356 * gv + 47953 * bv) >>> 16;
    sum_b = (10052 * rv + 20750 * gv + 3744 * bv) >>> 16;
    if (sum_a < sum_b) begin
      res.matrix = MatA;
      res.red    = round_sat(27940 * rv + 56171 * gv + 5251 * bv);
      res.green  = round_sat(18422 * rv + 37434 * gv - 2573 * bv);
      res.blue   = round_sat(-1160 * rv + 1770 * gv + 65698 * bv);
    end else begin
      res.matrix = MatB;
      res.red    = round_sat(49683 * rv + 95281 * gv - 97033 * bv);
      res.green  = round_sat(7768 * rv + 18848 * gv + 47546 * bv);
      res.blue   = round_sat(-489 * rv + 2941 * gv + 62541 * bv);
    end
    return res;
  endfunction

  task automatic compare_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  // Input beats queue a prediction; output beats are checked against the oldest one.
  always @(posedge clk_i) begin
    remap_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        remap_q.push_back(remap_color(red_in_i, green_in_i, blue_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (remap_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d matrix %0d",
                   $time, red_out_i, green_out_i, blue_out_i, matrix_used_i);
        end else begin
          want = remap_q.pop_front();
          compare_field("red_out", int'(want.red), int'(red_out_i));
          compare_field("green_out", int'(want.green), int'(green_out_i));
          compare_field("blue_out", int'(want.blue), int'(blue_out_i));
          compare_field("matrix_used", int'(want.matrix), int'(matrix_used_i));
          checked_o++;
          if (want.matrix == MatB) begin
            mat_b_count_o++;
          end
        end
      end
      pending_o = remap_q.size();
    end
  end

endmodule

### sim/dual_matrix_color_remap_unit_tb.sv
// Testbench top for the dual-matrix color remap unit: clock, reset, color stimulus,
// output back-pressure, a stall watchdog and the verdict.
// Depends on dmcr_pkg, the unit itself and dual_matrix_color_remap_checker.
`timescale 1ns / 1ps

module dual_matrix_color_remap_unit_tb;
  import dmcr_pkg::*;

  localparam int RandomColors = 1350;
  localparam int HoldOffCycles = 64;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  chan_t red_in_i = '0;
  chan_t green_in_i = '0;
  chan_t blue_in_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  chan_t red_out_o;
  chan_t green_out_o;
  chan_t blue_out_o;
  logic  matrix_used_o;

  int   mismatch_count;
  int   pending_count;
  int   checked_count;
  int   mat_b_count;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off_req = 1'b0;
  int   colors_sent = 0;
  int   stall_cycles = 0;

  always #2 clk_i = ~clk_i;

  dual_matrix_color_remap_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .matrix_used_o(matrix_used_o)
  );

  dual_matrix_color_remap_checker u_remap_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_out_i       (red_out_o),
    .green_out_i     (green_out_o),
    .blue_out_i      (blue_out_o),
    .matrix_used_i   (matrix_used_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count),
    .checked_o       (checked_count),
    .mat_b_count_o   (mat_b_count)
  );

  // Offers one color, idling first at the current rate, and returns on the beat.
  task automatic send_color(input chan_t r, input chan_t g, input chan_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    colors_sent++;
  endtask

  // A quarter of the channels come from the edges of the range, the rest uniform.
  function automatic chan_t pick_channel();
    chan_t       edges [6];
    logic  [2:0] edge_idx;
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(3) == 0) begin
      edge_idx = 3'($urandom_range(5));
      return edges[edge_idx];
    end
    return chan_t'($urandom_range(255));
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_color(pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  // Receiver: random stalls at the current rate, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no beat for %0d cycles, %0d results still expected",
                 StallLimit, pending_count);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed colors: black, white, primaries, secondaries, mid grays, and
    // colors that force the negative clamp, the saturation and the tie of the
    // two selection sums (black ties and takes the second matrix).
    send_idle_pct = 22;
    recv_idle_pct = 82;
    send_color(8'd0, 8'd0, 8'd0);
    send_color(8'd255, 8'd255, 8'd255);
    send_color(8'd255, 8'd0, 8'd0);
    send_color(8'd0, 8'd255, 8'd0);
    send_color(8'd0, 8'd0, 8'd255);
    send_color(8'd255, 8'd255, 8'd0);
    send_color(8'd255, 8'd0, 8'd255);
    send_color(8'd0, 8'd255, 8'd255);
    send_color(8'd1, 8'd1, 8'd1);
    send_color(8'd127, 8'd127, 8'd127);
    send_color(8'd128, 8'd128, 8'd128);
    send_color(8'd254, 8'd254, 8'd254);
    send_color(8'd0, 8'd0, 8'd1);
    send_color(8'd1, 8'd0, 8'd0);
    send_color(8'd0, 8'd1, 8'd0);
    send_color(8'd10, 8'd200, 8'd255);
    send_color(8'd255, 8'd255, 8'd30);
    send_color(8'd200, 8'd40, 8'd90);
    send_color(8'd85, 8'd170, 8'd85);
    send_color(8'd170, 8'd85, 8'd170);

    // Random colors under three idle mixes; the last one opens with a long
    // output hold-off while the sender keeps offering.
    send_random(RandomColors / 3);
    send_idle_pct = 82;
    recv_idle_pct = 22;
    send_random(RandomColors / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    send_random(RandomColors - 2 * (RandomColors / 3));
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d colors, checked %0d results (%0d through the second matrix),",
             colors_sent, checked_count, mat_b_count);
    $display("under three idle mixes and one long output hold-off.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### dual_matrix_color_remap_unit.f
design/dmcr_pkg.sv
design/dual_matrix_color_remap_unit.sv
sim/dual_matrix_color_remap_checker.sv
sim/dual_matrix_color_remap_unit_tb.sv
